// ===== hw/rtl/bda_pkg.sv =====
// Package: shared constants, back-end state type and constant-table functions.
`default_nettype none
package bda_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam int         CONST_W    = 68;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SIGN,
        BS_DIGIT
    } t_back_state;

    // k * 10**i, evaluated at elaboration only
    function automatic logic [CONST_W-1:0] bda_pow10_mult(input int unsigned i,
                                                           input int unsigned k);
        logic [CONST_W-1:0] p;
        p = CONST_W'(k);
        for (int j = 0; j < 20; j++) begin
            if (j < i) begin
                p = p * CONST_W'(10);
            end
        end
        return p;
    endfunction

    // decimal digit count of the largest unsigned value of width w
    function automatic int bda_num_digits(input int unsigned w);
        logic [CONST_W-1:0] maxv;
        logic [CONST_W-1:0] p;
        int                 n;
        maxv = (CONST_W'(1) << w) - CONST_W'(1);
        p    = CONST_W'(1);
        n    = 0;
        for (int j = 0; j < 21; j++) begin
            if (p <= maxv) begin
                n++;
            end
            p = p * CONST_W'(10);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bda_in_if.sv =====
// Interface: input channel carrying kind flag and raw value.
`default_nettype none
interface bda_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bda_out_if.sv =====
// Interface: output channel carrying one ASCII character and its last flag.
`default_nettype none
interface bda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bda_front.sv =====
// Front end: registers the input, takes the magnitude and sizes the digit string.
`default_nettype none
module bda_front #(
    parameter int VALUE_WIDTH = 32,
    localparam int NDIG    = bda_pkg::bda_num_digits(VALUE_WIDTH),
    localparam int POS_W   = $clog2(NDIG),
    localparam int ENTRY_W = 1 + POS_W + VALUE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bda_in_if.sink             i_in,
    output logic               o_push,
    input  logic               i_push_ready,
    output logic [ENTRY_W-1:0] o_data
);
    import bda_pkg::*;

    localparam int MW = VALUE_WIDTH + 4;

    logic                   r_full;
    logic                   r_kind;
    logic [VALUE_WIDTH-1:0] r_value;

    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [POS_W-1:0]       w_top;
    logic [MW-1:0]          w_pow [NDIG];

    for (genvar gi = 0; gi < NDIG; gi++) begin : g_pow
        localparam logic [CONST_W-1:0] PV = bda_pow10_mult(gi, 1);
        assign w_pow[gi] = PV[MW-1:0];
    end

    assign i_in.ready = !r_full || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_in.ready) begin
            r_full <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind  <= i_in.kind;
            r_value <= i_in.value;
        end
    end

    // most negative value wraps to 2**(W-1), which is the right magnitude
    assign w_neg = r_kind & r_value[VALUE_WIDTH-1];
    assign w_mag = w_neg ? (~r_value + VALUE_WIDTH'(1)) : r_value;

    // index of the leading digit: how many powers 10..10**(NDIG-1) fit
    always_comb begin
        w_top = '0;
        for (int i = 1; i < NDIG; i++) begin
            if ({4'b0000, w_mag} >= w_pow[i]) begin
                w_top = w_top + POS_W'(1);
            end
        end
    end

    assign o_push = r_full;
    assign o_data = {w_neg, w_top, w_mag};

endmodule
`default_nettype wire

// ===== hw/rtl/bda_fifo.sv =====
// Small flop-based queue between the front and back ends.
`default_nettype none
module bda_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_data       = r_mem[r_rptr];
    assign w_do_push    = i_push && o_push_ready;
    assign w_do_pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bda_back.sv =====
// Back end: minus if negative, then one digit per cycle unless stalled, MSD first.
`default_nettype none
module bda_back #(
    parameter int VALUE_WIDTH = 32,
    localparam int NDIG    = bda_pkg::bda_num_digits(VALUE_WIDTH),
    localparam int POS_W   = $clog2(NDIG),
    localparam int ENTRY_W = 1 + POS_W + VALUE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  logic [ENTRY_W-1:0] i_q_data,
    bda_out_if.source          o_out
);
    import bda_pkg::*;

    localparam int MW = VALUE_WIDTH + 4;

    t_back_state            r_state;
    t_back_state            n_state;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] n_mag;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [7:0]             r_out_char;
    logic [7:0]             n_out_char;
    logic                   r_out_last;
    logic                   n_out_last;

    logic [MW-1:0]          w_mult [NDIG][10];
    logic                   w_out_free;
    logic [3:0]             w_digit;
    logic [MW-1:0]          w_rest;

    // k * 10**i table, i = digit position, k = digit
    for (genvar gi = 0; gi < NDIG; gi++) begin : g_row
        for (genvar gk = 0; gk < 10; gk++) begin : g_col
            localparam logic [CONST_W-1:0] MV = bda_pow10_mult(gi, gk);
            assign w_mult[gi][gk] = MV[MW-1:0];
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    // digit at r_pos is the largest k with k*10**pos <= remainder
    always_comb begin
        w_digit = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if ({4'b0000, r_mag} >= w_mult[r_pos][k]) begin
                w_digit = 4'(k);
            end
        end
        w_rest = {4'b0000, r_mag} - w_mult[r_pos][w_digit];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_pos       = r_pos;
        n_out_valid = w_out_free ? 1'b0 : r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_mag   = i_q_data[VALUE_WIDTH-1:0];
                    n_pos   = i_q_data[VALUE_WIDTH +: POS_W];
                    n_state = i_q_data[ENTRY_W-1] ? BS_SIGN : BS_DIGIT;
                end
            end
            BS_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = BS_DIGIT;
                end
            end
            BS_DIGIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_ZERO + {4'b0000, w_digit};
                    n_out_last  = (r_pos == '0);
                    n_mag       = w_rest[VALUE_WIDTH-1:0];
                    if (r_pos == '0) begin
                        n_state = BS_IDLE;
                    end else begin
                        n_pos = r_pos - POS_W'(1);
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_pos      <= n_pos;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

`ifndef NO_ASSERTIONS
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_char == CHAR_MINUS) |-> !r_out_last)
        else $error("sign character flagged as last");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char == CHAR_MINUS ||
                         (r_out_char >= CHAR_ZERO && r_out_char <= CHAR_ZERO + 8'd9)))
        else $error("illegal output character");

    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SIGN && w_out_free) |=> (r_state == BS_DIGIT))
        else $error("sign not followed by digits");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// The input transfer is registered in the front end, queued, loaded by the back end and
// registered at the output as the first character. The back end emits one digit per
// cycle while the output is not stalled, which sets the rate of numbers.
// A two-entry queue lets the front end take the next number during output.
// Reset (synchronous, active low) empties the input stage, queue and output.
// Top level: decimal ASCII converter, front end, queue and back end.
`default_nettype none
module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bda_in_if.sink    i_in,
    bda_out_if.source o_out
);
    import bda_pkg::*;

    localparam int NDIG    = bda_num_digits(VALUE_WIDTH);
    localparam int POS_W   = $clog2(NDIG);
    localparam int ENTRY_W = 1 + POS_W + VALUE_WIDTH;

    logic               w_push;
    logic               w_push_ready;
    logic [ENTRY_W-1:0] w_push_data;
    logic               w_q_valid;
    logic               w_q_pop;
    logic [ENTRY_W-1:0] w_q_data;

    bda_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_data       (w_push_data)
    );

    bda_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_data       (w_push_data),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_data       (w_q_data)
    );

    bda_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_data  (w_q_data),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

// ===== verif/binary_to_decimal_ascii_tb.sv =====
// Testbench for binary_to_decimal_ascii: directed and random numbers, checked per character.
module binary_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bda_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_text_char;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_off = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;

    t_text_char expected_text[$];

    bda_in_if #(.VALUE_WIDTH(32)) in_ch ();
    bda_out_if out_ch ();

    binary_to_decimal_ascii #(
        .VALUE_WIDTH(32)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #2 clk = ~clk;

    // Decimal text of one number, sign first, then digits MSD first.
    function automatic void predict_text(input logic kind, input logic [31:0] value);
        logic [31:0] mag;
        logic [3:0]  digits [10];
        int          n;
        mag = value;
        n   = 0;
        if (kind && value[31]) begin
            mag = ~value + 32'd1;
            expected_text.push_back('{CHAR_MINUS, 1'b0});
        end
        do begin
            digits[n] = 4'(mag % 32'd10);
            mag       = mag / 32'd10;
            n++;
        end while (mag != 32'd0);
        for (int i = n - 1; i >= 0; i--) begin
            expected_text.push_back('{CHAR_ZERO + 8'(digits[i]), i == 0});
        end
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned p;
        int unsigned d;
        p = 1;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 99);
            2: begin
                d = $urandom_range(1, 9);
                repeat (d) p = p * 10;
                return $urandom_range(p - 1, p / 10);
            end
            3: begin
                // around a power of ten, where the digit count changes
                repeat ($urandom_range(0, 9)) p = p * 10;
                return p + $urandom_range(0, 2) - 1;
            end
            4: return 32'd0 - $urandom_range(1, 1000);
            default: begin
                case ($urandom_range(0, 2))
                    0: return 32'h8000_0000 + $urandom_range(0, 15);
                    1: return 32'h7FFF_FFFF - $urandom_range(0, 15);
                    default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
                endcase
            end
        endcase
    endfunction

    task automatic send_number(input logic kind, input logic [31:0] value);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        do @(posedge clk); while (!in_ch.ready);
        predict_text(kind, value);
    endtask

    // Receiver: random stalls, plus a forced hold-off while hold_off is set.
    always @(posedge clk) begin
        out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        t_text_char got;
        t_text_char want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.character, out_ch.last};
            if (expected_text.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: unexpected char 0x%02h last=%0b", got.character, got.last);
                end
            end else begin
                want = expected_text.pop_front();
                if (got.character !== want.character || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                                 want.character, got.character, want.last, got.last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("binary_to_decimal_ascii_tb failed");
                $finish;
            end
        end
    end

    task automatic test_directed_values();
        logic [32:0] cases [] = '{
            {1'b0, 32'd0},          {1'b1, 32'd0},          {1'b0, 32'd1},
            {1'b0, 32'd9},          {1'b0, 32'd10},         {1'b1, 32'd99},
            {1'b0, 32'd100},        {1'b1, 32'd999999999},  {1'b0, 32'd1000000000},
            {1'b0, 32'hFFFF_FFFF},  {1'b1, 32'hFFFF_FFFF},  {1'b0, 32'h8000_0000},
            {1'b1, 32'h8000_0000},  {1'b0, 32'h7FFF_FFFF},  {1'b1, 32'h7FFF_FFFF},
            {1'b1, 32'hFFFF_FFF6},  {1'b1, 32'hC465_3600},  {1'b1, 32'h8000_0001},
            {1'b0, 32'hAAAA_AAAA},  {1'b1, 32'h5555_5555},  {1'b0, 32'd4294967286},
            {1'b1, 32'd12345}
        };
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (cases[i]) send_number(cases[i][32], cases[i][31:0]);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_number($urandom_range(0, 1), pick_value());
    endtask

    // Output held off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
            repeat (12) send_number($urandom_range(0, 1), pick_value());
        join
    endtask

    initial begin
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.kind   <= 1'b0;
        in_ch.value  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_random_traffic(0, 0, 46);
        test_random_traffic(60, 0, 46);
        test_random_traffic(0, 60, 46);
        test_random_traffic(30, 30, 46);
        test_output_backpressure();

        in_ch.valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("binary_to_decimal_ascii_tb passed");
        end else begin
            $display("binary_to_decimal_ascii_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bda_pkg.sv
hw/rtl/bda_in_if.sv
hw/rtl/bda_out_if.sv
hw/rtl/bda_front.sv
hw/rtl/bda_fifo.sv
hw/rtl/bda_back.sv
hw/rtl/binary_to_decimal_ascii.sv
verif/binary_to_decimal_ascii_tb.sv
